/* design/ihtc_pkg.sv */
// ----------------------------------------------------------------------------
// ihtc_pkg
// Shared types, constants and the arctangent table of the heading controller.
// ----------------------------------------------------------------------------
package ihtc_pkg;

  // Parameter defaults
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int QUAT_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Register file
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ANGLE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_TOLERANCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIN_RATE       = 2'd2;

  localparam logic [15:0] TARGET_ANGLE_RST    = 16'd32768;
  localparam logic [15:0] ANGLE_TOLERANCE_RST = 16'd313;
  localparam logic [15:0] SPIN_RATE_RST       = 16'd256;

  // CORDIC datapath: vector components and 32-bit binary angle (2^31 = pi)
  localparam int CORDIC_W   = 36;
  localparam int STEP_IDX_W = 5;
  localparam logic [31:0] ANG_PLUS_HALF_PI  = 32'h4000_0000;
  localparam logic [31:0] ANG_MINUS_HALF_PI = 32'hC000_0000;

  // Product operand pairs
  typedef enum logic [1:0] {
    MUL_WZ = 2'd0,
    MUL_XY = 2'd1,
    MUL_YY = 2'd2,
    MUL_ZZ = 2'd3
  } mul_sel_t;

  // Accumulator operations on the registered product
  typedef enum logic [2:0] {
    ACC_NONE  = 3'd0,
    ACC_Y_SET = 3'd1,
    ACC_Y_ADD = 3'd2,
    ACC_X_SET = 3'd3,
    ACC_X_ADD = 3'd4
  } acc_op_t;

  // Controller to datapath
  typedef struct packed {
    logic                  load;
    mul_sel_t              mul_sel;
    acc_op_t               acc_op;
    logic                  prep;
    logic                  iter;
    logic [STEP_IDX_W-1:0] step_idx;
    logic                  save;
    logic                  result;
  } ihtc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ref_valid;
  } ihtc_status_t;

  // atan(2^-i) in 32-bit binary angle units
  function automatic logic [31:0] atan_lut(input logic [STEP_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* design/ihtc_ctrl.sv */
// ----------------------------------------------------------------------------
// ihtc_ctrl
// Sequencer: multiply/accumulate, CORDIC iterations, heading store and
// control-tick result, plus the input and output handshakes.
// ----------------------------------------------------------------------------
module ihtc_ctrl
  import ihtc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         kind,
  output logic         out_valid,
  input  logic         out_stall,
  output ihtc_cmd_t    cmd,
  input  ihtc_status_t status
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [2:0] MUL_LAST = 3'd4;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_PREP = 6'b000100,
    ST_ITER = 6'b001000,
    ST_SAVE = 6'b010000,
    ST_TICK = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [2:0]        mul_cnt, mul_cnt_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              out_valid_next;
  logic              in_accept;
  logic              slot_free;
  logic              step_last;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign step_last = (step_cnt == STEP_LAST);

  // Next state and commands
  always_comb begin
    state_next    = state;
    mul_cnt_next  = mul_cnt;
    step_cnt_next = step_cnt;
    cmd           = '0;
    cmd.mul_sel   = MUL_WZ;
    cmd.acc_op    = ACC_NONE;
    cmd.step_idx  = STEP_IDX_W'(step_cnt);
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.load     = 1'b1;
          mul_cnt_next = '0;
          state_next   = kind ? ST_TICK : ST_MUL;
        end
      end
      ST_MUL: begin
        // product issued in the cycle before it is accumulated
        case (mul_cnt)
          3'd0:    cmd.mul_sel = MUL_WZ;
          3'd1:    cmd.mul_sel = MUL_XY;
          3'd2:    cmd.mul_sel = MUL_YY;
          3'd3:    cmd.mul_sel = MUL_ZZ;
          default: cmd.mul_sel = MUL_WZ;
        endcase
        case (mul_cnt)
          3'd1:    cmd.acc_op = ACC_Y_SET;
          3'd2:    cmd.acc_op = ACC_Y_ADD;
          3'd3:    cmd.acc_op = ACC_X_SET;
          3'd4:    cmd.acc_op = ACC_X_ADD;
          default: cmd.acc_op = ACC_NONE;
        endcase
        mul_cnt_next = mul_cnt + 3'd1;
        if (mul_cnt == MUL_LAST) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep      = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_last) begin
          state_next = ST_SAVE;
        end
      end
      ST_SAVE: begin
        cmd.save   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TICK: begin
        // no result before the first sample; otherwise wait for the slot
        if (!status.ref_valid) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          cmd.result = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register valid: held while stalled, loaded by a result
  assign out_valid_next = (out_valid && out_stall) || cmd.result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_cnt   <= '0;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mul_cnt   <= mul_cnt_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Assertions
  a_sample_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && !kind) |=> (state == ST_MUL))
    else $error("orientation sample did not start the multiply phase");

  a_iter_ends_in_save: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER && step_last) |=> (state == ST_SAVE))
    else $error("last CORDIC step not followed by heading store");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> (!out_valid || !out_stall))
    else $error("result written over an untaken transfer");

endmodule

/* design/ihtc_datapath.sv */
// ----------------------------------------------------------------------------
// ihtc_datapath
// Quaternion products, CORDIC vectoring to yaw, heading state, turn
// comparison, configuration registers and the result register.
// ----------------------------------------------------------------------------
module ihtc_datapath
  import ihtc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int QUAT_BITS  = QUAT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ihtc_cmd_t                     cmd,
  output ihtc_status_t                  status,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [QUAT_BITS-1:0]   quat_x,
  input  logic signed [QUAT_BITS-1:0]   quat_y,
  input  logic signed [QUAT_BITS-1:0]   quat_z,
  input  logic signed [QUAT_BITS-1:0]   quat_w,
  output logic signed [15:0]            angular_command,
  output logic [15:0]                   turned_angle,
  output logic                          turn_done
);

  localparam int PAD_W = 48 - QUAT_BITS;
  localparam int CMP_W = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
  localparam logic [32:0] ROUND_HALF = (33'd1 << (32 - ANGLE_BITS)) >> 1;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [CORDIC_W-1:0] X_BIAS = CORDIC_W'(64'sd1 <<< 30);

  // Top 16 bits of a component: floor for wide inputs, zero fill for narrow
  function automatic logic signed [15:0] to_q15(input logic [QUAT_BITS-1:0] raw);
    logic [47:0] ext;
    ext = {raw, {PAD_W{1'b0}}};
    return $signed(ext[47:32]);
  endfunction

  // Configuration registers
  logic [15:0]        target_angle;
  logic [15:0]        angle_tolerance;
  logic signed [15:0] spin_rate;

  // Heading state
  logic [ANGLE_BITS-1:0] heading_now;
  logic [ANGLE_BITS-1:0] heading_reference;
  logic                  reference_valid;
  logic                  finished;

  // Working registers
  logic signed [15:0]         qx, qy, qz, qw;
  logic signed [31:0]         prod;
  logic signed [32:0]         acc_y, acc_x;
  logic signed [CORDIC_W-1:0] cx, cy;
  logic [31:0]                ang;
  logic                       zero_vec;

  // Combinational terms
  logic signed [15:0]         mul_a, mul_b;
  logic signed [CORDIC_W-1:0] x0, y0;
  logic signed [CORDIC_W-1:0] dx, dy;
  logic [31:0]                atan_step;
  logic [32:0]                ang_rnd;
  logic [ANGLE_BITS-1:0]      heading_new;
  logic [ANGLE_BITS-1:0]      diff, diff_neg, turned;
  logic signed [16:0]         threshold;
  logic signed [CMP_W-1:0]    turned_s, threshold_s;
  logic                       below;

  assign status.ref_valid = reference_valid;

  // Multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_WZ:  begin mul_a = qw; mul_b = qz; end
      MUL_XY:  begin mul_a = qx; mul_b = qy; end
      MUL_YY:  begin mul_a = qy; mul_b = qy; end
      MUL_ZZ:  begin mul_a = qz; mul_b = qz; end
      default: begin mul_a = qw; mul_b = qz; end
    endcase
  end

  // Start vector: x = 2^30 - 2(yy+zz), y = 2(wz+xy)
  assign x0 = X_BIAS - (CORDIC_W'(acc_x) <<< 1);
  assign y0 = CORDIC_W'(acc_y) <<< 1;

  // One vectoring step
  assign dx        = cy >>> cmd.step_idx;
  assign dy        = cx >>> cmd.step_idx;
  assign atan_step = atan_lut(cmd.step_idx);

  // Round half up to the output angle width; the carry out wraps
  assign ang_rnd     = {1'b0, ang} + ROUND_HALF;
  assign heading_new = zero_vec ? '0 : ang_rnd[31 -: ANGLE_BITS];

  // Wrapped absolute heading change and the stop threshold
  assign diff        = heading_now - heading_reference;
  assign diff_neg    = '0 - diff;
  assign turned      = (diff <= HALF_TURN) ? diff : diff_neg;
  assign threshold   = $signed({1'b0, target_angle}) - $signed({1'b0, angle_tolerance});
  assign turned_s    = $signed(CMP_W'(turned));
  assign threshold_s = CMP_W'(threshold);
  assign below       = (turned_s < threshold_s);

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle      <= TARGET_ANGLE_RST;
      angle_tolerance   <= ANGLE_TOLERANCE_RST;
      spin_rate         <= SPIN_RATE_RST;
      heading_now       <= '0;
      heading_reference <= '0;
      reference_valid   <= 1'b0;
      finished          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET_ANGLE:    target_angle    <= cfg_data;
          REG_ANGLE_TOLERANCE: angle_tolerance <= cfg_data;
          REG_SPIN_RATE:       spin_rate       <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (cmd.save) begin
        heading_now <= heading_new;
        if (!reference_valid) begin
          heading_reference <= heading_new;
          reference_valid   <= 1'b1;
        end
      end
      if (cmd.result && !below) begin
        finished <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx <= to_q15(quat_x);
      qy <= to_q15(quat_y);
      qz <= to_q15(quat_z);
      qw <= to_q15(quat_w);
    end

    prod <= mul_a * mul_b;

    case (cmd.acc_op)
      ACC_Y_SET: acc_y <= 33'(prod);
      ACC_Y_ADD: acc_y <= acc_y + 33'(prod);
      ACC_X_SET: acc_x <= 33'(prod);
      ACC_X_ADD: acc_x <= acc_x + 33'(prod);
      default: ;
    endcase

    // Pre-rotation by a quarter turn when the vector points backwards
    if (cmd.prep) begin
      zero_vec <= (x0 == '0) && (y0 == '0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          cx  <= y0;
          cy  <= -x0;
          ang <= ANG_PLUS_HALF_PI;
        end else begin
          cx  <= -y0;
          cy  <= x0;
          ang <= ANG_MINUS_HALF_PI;
        end
      end else begin
        cx  <= x0;
        cy  <= y0;
        ang <= '0;
      end
    end else if (cmd.iter) begin
      if (cy >= 0) begin
        cx  <= cx + dx;
        cy  <= cy - dy;
        ang <= ang + atan_step;
      end else begin
        cx  <= cx - dx;
        cy  <= cy + dy;
        ang <= ang - atan_step;
      end
    end

    // Result register
    if (cmd.result) begin
      angular_command <= (!finished && below) ? spin_rate : '0;
      turned_angle    <= 16'(turned);
      turn_done       <= finished || !below;
    end
  end

  // Assertions
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("turn done flag cleared without reset");

  a_ref_sticky: assert property (@(posedge clk) disable iff (rst)
    reference_valid |=> (reference_valid && $stable(heading_reference)))
    else $error("reference heading changed after it was latched");

  a_done_means_zero_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.result |=> (!turn_done || angular_command == '0))
    else $error("non-zero rate commanded after the turn finished");

endmodule

/* design/imu_heading_half_turn_control_core.sv */
// ----------------------------------------------------------------------------
// imu_heading_half_turn_control_core - yaw from quaternion, half-turn control
// Orientation sample: the input stalls while the shared multiplier forms
// the products and the serial CORDIC vectors them, until the heading is stored.
// Control tick: input stalls until its result, if any, is registered in a free slot.
// Synchronous reset clears heading state and loads register defaults.
// ----------------------------------------------------------------------------
module imu_heading_half_turn_control_core
  import ihtc_pkg::*;
#(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int QUAT_BITS    = QUAT_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic signed [QUAT_BITS-1:0] quat_x,
  input  logic signed [QUAT_BITS-1:0] quat_y,
  input  logic signed [QUAT_BITS-1:0] quat_z,
  input  logic signed [QUAT_BITS-1:0] quat_w,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          angular_command,
  output logic [15:0]                 turned_angle,
  output logic                        turn_done
);

  ihtc_cmd_t    cmd;
  ihtc_status_t status;

  // Sequencer
  ihtc_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and state
  ihtc_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .QUAT_BITS  (QUAT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .quat_x          (quat_x),
    .quat_y          (quat_y),
    .quat_z          (quat_z),
    .quat_w          (quat_w),
    .angular_command (angular_command),
    .turned_angle    (turned_angle),
    .turn_done       (turn_done)
  );

endmodule

/* bench/imu_heading_half_turn_control_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_heading_half_turn_control_core_tb - heading controller regression
// Drives orientation samples and control ticks through the valid/stall
// handshake, tracks yaw, reference and the done latch in a local model and
// compares every tick report field by field. A short directed table opens the
// run; random phases with varied idling, a long receiver hold-off and several
// register settings follow. The finishing cases and random runs with done set
// come last, as done only clears on reset.
// ----------------------------------------------------------------------------
module imu_heading_half_turn_control_core_tb;
  import ihtc_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  // quiet time for a sample still in the CORDIC before a register write
  localparam int SETTLE_CYCLES = CORDIC_STEPS_DEF + 12;

  // atan(2^-i), 32-bit binary angle, 2^31 = pi
  localparam logic [0:15][31:0] ATAN_BAM = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic               kind;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_item_t;

  typedef struct packed {
    logic signed [15:0] command;
    logic [15:0]        turned;
    logic               done;
  } turn_report_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE = 2'd0,
    ROW_TICK   = 2'd1,
    ROW_CFG    = 2'd2
  } plan_op_t;

  // register writes keep the index in qx and the value in qy
  typedef struct packed {
    plan_op_t           op;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               typed;
    turn_report_t       want;
  } plan_row_t;

  // DUT connections
  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   kind      = KIND_SAMPLE;
  logic signed [15:0]     quat_x    = '0;
  logic signed [15:0]     quat_y    = '0;
  logic signed [15:0]     quat_z    = '0;
  logic signed [15:0]     quat_w    = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [15:0]     angular_command;
  logic [15:0]            turned_angle;
  logic                   turn_done;

  // heading tracker state and register copies
  logic [15:0]        head_now, head_ref;
  logic               ref_seen, turn_latched;
  logic [15:0]        tgt_angle, tol_angle;
  logic signed [15:0] rate_cmd;

  turn_report_t turn_reports_due[$];
  plan_row_t    plan_rows[$];
  int           open_rows;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  int n_errors     = 0;
  int n_samples    = 0;
  int n_ticks      = 0;
  int n_checked    = 0;
  int n_reg_writes = 0;

  imu_heading_half_turn_control_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .quat_x          (quat_x),
    .quat_y          (quat_y),
    .quat_z          (quat_z),
    .quat_w          (quat_w),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .angular_command (angular_command),
    .turned_angle    (turned_angle),
    .turn_done       (turn_done)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    #10ms;
    $display("Timeout: results still outstanding");
    $display("Regression FAIL");
    $finish;
  end

  // Yaw of a Q1.15 quaternion as a 16-bit binary angle (serial CORDIC)
  function automatic logic [15:0] yaw_of_quat(input logic signed [15:0] qx, qy, qz, qw);
    longint      vx, vy, swap, dx, dy;
    logic [31:0] ang;
    logic [32:0] rounded;
    vy  = 2 * (longint'(qw) * longint'(qz) + longint'(qx) * longint'(qy));
    vx  = (longint'(1) << 30) - 2 * (longint'(qy) * longint'(qy) + longint'(qz) * longint'(qz));
    ang = '0;
    if (vx == 0 && vy == 0)
      return '0;
    // left half plane: quarter-turn pre-rotation
    if (vx < 0) begin
      swap = vx;
      if (vy >= 0) begin
        vx  = vy;
        vy  = -swap;
        ang = ANG_PLUS_HALF_PI;
      end else begin
        vx  = -vy;
        vy  = swap;
        ang = ANG_MINUS_HALF_PI;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        ang = ang + ATAN_BAM[i];
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        ang = ang - ATAN_BAM[i];
      end
    end
    rounded = {1'b0, ang} + 33'h0_0000_8000;
    return rounded[31:16];
  endfunction

  // Update the tracker for one accepted transfer; queue a report for a tick
  task automatic track_heading(input quat_item_t it, input logic typed,
                               input turn_report_t want);
    logic [15:0]  diff;
    turn_report_t got;
    int           threshold;
    if (it.kind == KIND_SAMPLE) begin
      n_samples++;
      head_now = yaw_of_quat(it.qx, it.qy, it.qz, it.qw);
      if (!ref_seen) begin
        head_ref = head_now;
        ref_seen = 1'b1;
      end
    end else begin
      n_ticks++;
      if (ref_seen) begin
        diff        = head_now - head_ref;
        got.turned  = (diff <= 16'h8000) ? diff : 16'(16'd0 - diff);
        got.command = '0;
        if (!turn_latched) begin
          threshold = int'(tgt_angle) - int'(tol_angle);
          if (int'(got.turned) < threshold)
            got.command = rate_cmd;
          else
            turn_latched = 1'b1;
        end
        got.done = turn_latched;
        turn_reports_due.push_back(typed ? want : got);
      end
    end
  endtask

  // Offer one item, with random idle cycles ahead of it, until transferred
  task automatic offer(input quat_item_t it, input logic typed, input turn_report_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= it.kind;
    quat_x   <= it.qx;
    quat_y   <= it.qy;
    quat_z   <= it.qz;
    quat_w   <= it.qw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_heading(it, typed, want);
  endtask

  // Register write once every report is in and the CORDIC has gone quiet
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (turn_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_reg_writes++;
    case (idx)
      REG_TARGET_ANGLE:    tgt_angle = val;
      REG_ANGLE_TOLERANCE: tol_angle = val;
      REG_SPIN_RATE:       rate_cmd  = val;
      default: ;
    endcase
  endtask

  function automatic void add_row(input plan_op_t op, input logic [15:0] a, b, c, d,
                                  input logic typed, input logic [15:0] cmd, ang,
                                  input logic done);
    plan_row_t r;
    r.op           = op;
    r.qx           = a;
    r.qy           = b;
    r.qz           = c;
    r.qw           = d;
    r.typed        = typed;
    r.want.command = cmd;
    r.want.turned  = ang;
    r.want.done    = done;
    plan_rows.push_back(r);
  endfunction

  task automatic walk_plan(input int first, input int last);
    plan_row_t  r;
    quat_item_t it;
    for (int i = first; i < last; i++) begin
      r = plan_rows[i];
      if (r.op == ROW_CFG) begin
        write_register(r.qx[CFG_INDEX_W-1:0], r.qy);
      end else begin
        it.kind = (r.op == ROW_TICK) ? KIND_TICK : KIND_SAMPLE;
        it.qx   = r.qx;
        it.qy   = r.qy;
        it.qz   = r.qz;
        it.qw   = r.qw;
        offer(it, r.typed, r.want);
      end
    end
  endtask

  // Component biased towards the extremes, zero and small values
  function automatic logic signed [15:0] random_component();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(input int count);
    quat_item_t it;
    for (int n = 0; n < count; n++) begin
      it.kind = ($urandom_range(99) < 40) ? KIND_TICK : KIND_SAMPLE;
      it.qx   = random_component();
      it.qy   = random_component();
      it.qz   = random_component();
      it.qw   = random_component();
      offer(it, 1'b0, '0);
    end
  endtask

  // Result side: random or held stall, check on every transfer
  initial begin : result_sink
    turn_report_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (turn_reports_due.size() == 0) begin
          $error("unexpected report: command %0d, turned %0d, done %0d",
                 angular_command, turned_angle, turn_done);
          n_errors++;
        end else begin
          want = turn_reports_due.pop_front();
          n_checked++;
          if (angular_command !== want.command) begin
            $error("angular_command: expected %0d, got %0d", want.command, angular_command);
            n_errors++;
          end
          if (turned_angle !== want.turned) begin
            $error("turned_angle: expected %0d, got %0d", want.turned, turned_angle);
            n_errors++;
          end
          if (turn_done !== want.done) begin
            $error("turn_done: expected %0d, got %0d", want.done, turn_done);
            n_errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    head_now     = '0;
    head_ref     = '0;
    ref_seen     = 1'b0;
    turn_latched = 1'b0;
    tgt_angle    = TARGET_ANGLE_RST;
    tol_angle    = ANGLE_TOLERANCE_RST;
    rate_cmd     = SPIN_RATE_RST;

    // tick before any sample: no report, no state change
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);
    // zero vector: yaw exactly zero, latched as reference
    add_row(ROW_SAMPLE, 0, 16384, 16384, 0, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 1, 16'd256, 0, 0);
    add_row(ROW_SAMPLE, 0, 0, 0, 16'h7FFF, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 0, 23170, 23170, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);
    // zero tolerance at full target: only an exact half turn finishes
    add_row(ROW_CFG,    REG_ANGLE_TOLERANCE, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG,    REG_SPIN_RATE, 16'h7FFF, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 16384, 16384, 0, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 1, 16'h7FFF, 0, 0);
    add_row(ROW_CFG,    REG_SPIN_RATE, 16'h8000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 1, 16'h8000, 0, 0);
    add_row(ROW_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 0, 23170, 16'hA57E, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);
    open_rows = plan_rows.size();
    // tolerance above target: negative threshold, first tick finishes
    add_row(ROW_CFG,    REG_TARGET_ANGLE, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG,    REG_ANGLE_TOLERANCE, 16'h8000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 16384, 16384, 0, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 1, 0, 0, 1);
    add_row(ROW_CFG,    REG_TARGET_ANGLE, 16'h8000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG,    REG_ANGLE_TOLERANCE, 0, 0, 0, 0, 0, 0, 0);
    // half turn from the zero reference, then already finished
    add_row(ROW_SAMPLE, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 0, 16'h7FFF, 0, 0, 0, 0, 0);
    add_row(ROW_TICK,   0, 0, 0, 0, 0, 0, 0, 0);

    send_idle_pct  = 26;
    recv_stall_pct = 54;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    walk_plan(0, open_rows);

    // random, unfinished: target pi, zero tolerance, varied spin rate
    write_register(REG_SPIN_RATE, 16'($urandom));
    run_random(240);

    send_idle_pct  = 54;
    recv_stall_pct = 26;
    write_register(REG_SPIN_RATE, 16'h0000);
    run_random(240);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_register(REG_SPIN_RATE, 16'($urandom));
    run_random(240);

    // long receiver hold-off while the sender keeps offering
    hold_cycles = 400;
    run_random(240);

    // finishing cases, then random with the done latch set
    send_idle_pct  = 26;
    recv_stall_pct = 54;
    walk_plan(open_rows, plan_rows.size());
    for (int p = 0; p < 4; p++) begin
      write_register(REG_TARGET_ANGLE, 16'($urandom_range(32768)));
      write_register(REG_ANGLE_TOLERANCE, 16'($urandom_range(32768)));
      write_register(REG_SPIN_RATE, 16'($urandom));
      run_random(60);
    end

    // drain
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (turn_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (turn_reports_due.size() != 0) begin
      $error("%0d reports never arrived", turn_reports_due.size());
      n_errors++;
    end

    $display("Covered %0d orientation samples and %0d control ticks, %0d reports compared.",
             n_samples, n_ticks, n_checked);
    $display("%0d register writes across spin, target and tolerance settings, done latched: %0d.",
             n_reg_writes, turn_latched);
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* imu_heading_half_turn_control_core.f */
design/ihtc_pkg.sv
design/ihtc_ctrl.sv
design/ihtc_datapath.sv
design/imu_heading_half_turn_control_core.sv
bench/imu_heading_half_turn_control_core_tb.sv
